### design/plob_pkg.sv
// Package for the price level order book: widths, codes and shared types.
`default_nettype none
package plob_pkg;
  localparam int LEVELS    = 64;
  localparam int MAX_QUERY = 16;
  localparam int AW        = $clog2(LEVELS);
  localparam int CW        = $clog2(LEVELS + 1);
  localparam int PW        = 32;
  localparam int VW        = 48;
  localparam int EW        = PW + VW;

  typedef enum logic [1:0] {
    KIND_DELTA = 2'd0,
    KIND_BEST  = 2'd1,
    KIND_VOL   = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_NOTF  = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  // result strobe bundle from the sequencer
  typedef struct packed {
    logic          valid;
    status_t       status;
    logic [3:0]    rank;
    logic [PW-1:0] price;
    logic [VW-1:0] volume;
    logic          last;
  } res_t;
endpackage
`default_nettype wire

### design/plob_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
`default_nettype none
module plob_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### design/plob_seq.sv
// Sequencer: scans, shifts and lists entries of one side's level memory.
`default_nettype none
module plob_seq (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  input  wire logic [1:0]             kind,
  input  wire logic                   side,
  input  wire logic [31:0]            price,
  input  wire logic [47:0]            volume,
  input  wire logic [4:0]             count,
  output logic                        busy,
  output logic                        we,
  output logic                        wside,
  output logic [plob_pkg::AW-1:0]     waddr,
  output logic [plob_pkg::EW-1:0]     wdata,
  output logic [plob_pkg::AW-1:0]     raddr,
  input  wire logic [plob_pkg::EW-1:0] rdata,
  output logic                        rside,
  output plob_pkg::res_t              res
);
  import plob_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SCAN  = 7'b0000010,
    S_DEC   = 7'b0000100,
    S_SHUP  = 7'b0001000,
    S_SHDN  = 7'b0010000,
    S_LIST  = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t        state;
  kind_t         k;
  logic          sd;
  logic [PW-1:0] pr;
  logic [VW-1:0] vo;
  logic [CW-1:0] bid_count, ask_count, n;
  logic [CW-1:0] idx;      // address of the entry in flight
  logic [CW-1:0] pos;
  logic [CW-1:0] m;        // results to list
  logic [CW-1:0] j;        // list counter
  logic          re;       // read address registered this cycle
  logic          rv;       // read data valid on rdata
  logic [PW-1:0] rp;
  logic [VW-1:0] rvol;
  logic [EW-1:0] hold;     // carried entry for insert shift
  logic [4:0]    cq;

  assign rp   = rdata[EW-1:VW];
  assign rvol = rdata[VW-1:0];
  assign n    = sd ? ask_count : bid_count;
  assign busy = (state != S_IDLE);
  assign rside = sd;
  assign wside = sd;

  always_ff @(posedge clk) begin
    res.valid <= 1'b0;
    we        <= 1'b0;
    re        <= 1'b0;
    // address register, then RAM output register; rv marks rdata valid
    rv        <= re;
    if (rst) begin
      state     <= S_IDLE;
      bid_count <= '0;
      ask_count <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            k  <= kind_t'(kind);
            sd <= side;
            pr <= price;
            vo <= volume;
            cq <= count;
            idx <= '0;
            raddr <= '0;
            re <= (kind_t'(kind) == KIND_DELTA) || (kind_t'(kind) == KIND_VOL);
            if (kind_t'(kind) == KIND_NONE) state <= S_IDLE;
            else if (kind_t'(kind) == KIND_BEST) state <= S_LIST;
            else state <= S_SCAN;
            j <= '0;
          end
        end
        // linear search for first entry with price >= pr
        S_SCAN: begin
          if (!rv) begin
            // read still in flight
            state <= S_SCAN;
          end else if (idx >= n || rp >= pr) begin
            pos <= idx;
            state <= S_DEC;
            hold <= rdata;
          end else begin
            idx <= idx + 1'b1;
            raddr <= AW'(idx + 1'b1);
            re <= 1'b1;
          end
        end
        S_DEC: begin
          res.valid <= 1'b1;
          res.rank  <= '0;
          res.price <= pr;
          res.last  <= 1'b1;
          res.status <= ST_OK;
          res.volume <= '0;
          state <= S_IDLE;
          if (k == KIND_VOL) begin
            if (n == 0) res.status <= ST_EMPTY;
            else if (pos < n && rp == pr) res.volume <= rvol;
            else res.status <= ST_NOTF;
          end else if (vo == '0) begin
            if (pos < n && rp == pr) begin
              // remove: pull entries down from pos+1
              if (pos + 1'b1 < n) begin
                idx <= pos + 1'b1;
                raddr <= AW'(pos + 1'b1);
                re <= 1'b1;
                res.valid <= 1'b0;
                state <= S_SHDN;
              end else begin
                if (sd) ask_count <= ask_count - 1'b1;
                else bid_count <= bid_count - 1'b1;
              end
            end else res.status <= ST_NOTF;
          end else if (pos < n && rp == pr) begin
            res.volume <= vo;
            we <= 1'b1;
            waddr <= AW'(pos);
            wdata <= {pr, vo};
          end else if (n >= CW'(LEVELS)) begin
            res.status <= ST_FULL;
          end else begin
            res.volume <= vo;
            we <= 1'b1;
            waddr <= AW'(pos);
            wdata <= {pr, vo};
            if (pos < n) begin
              // hold = old entry at pos, shift up
              idx <= pos + 1'b1;
              raddr <= AW'(pos + 1'b1);
              re <= 1'b1;
              res.valid <= 1'b0;
              state <= S_SHUP;
            end else begin
              if (sd) ask_count <= ask_count + 1'b1;
              else bid_count <= bid_count + 1'b1;
            end
          end
        end
        // insert: write carried entry at idx, carry the old one on
        S_SHUP: begin
          if (rv) begin
            we <= 1'b1;
            waddr <= AW'(idx);
            wdata <= hold;
            hold <= rdata;
            if (idx == n) begin
              if (sd) ask_count <= ask_count + 1'b1;
              else bid_count <= bid_count + 1'b1;
              res <= '{valid: 1'b1, status: ST_OK, rank: '0, price: pr,
                       volume: vo, last: 1'b1};
              state <= S_IDLE;
            end else begin
              idx <= idx + 1'b1;
              raddr <= AW'(idx + 1'b1);
              re <= 1'b1;
            end
          end
        end
        // remove: alternate read then write one slot down
        S_SHDN: begin
          if (rv) begin
            we <= 1'b1;
            waddr <= AW'(idx - 1'b1);
            wdata <= rdata;
            if (idx + 1'b1 >= n) begin
              if (sd) ask_count <= ask_count - 1'b1;
              else bid_count <= bid_count - 1'b1;
              res <= '{valid: 1'b1, status: ST_OK, rank: '0, price: pr,
                       volume: '0, last: 1'b1};
              state <= S_IDLE;
            end else begin
              idx <= idx + 1'b1;
              raddr <= AW'(idx + 1'b1);
              re <= 1'b1;
            end
          end
        end
        S_LIST: begin
          // compute m = min(count, MAX_QUERY, n), first read address
          if (CW'(cq) <= CW'(MAX_QUERY) && CW'(cq) <= n) m <= CW'(cq);
          else if (CW'(MAX_QUERY) <= n) m <= CW'(MAX_QUERY);
          else m <= n;
          if (cq == '0 || n == '0) begin
            res <= '{valid: 1'b1, status: ST_EMPTY, rank: '0, price: '0,
                     volume: '0, last: 1'b1};
            state <= S_IDLE;
          end else begin
            raddr <= sd ? '0 : AW'(n - 1'b1);
            re <= 1'b1;
            state <= S_OUT;
          end
        end
        // the next read goes out with each result
        S_OUT: begin
          if (rv) begin
            res.valid  <= 1'b1;
            res.status <= ST_OK;
            res.rank   <= j[3:0];
            res.price  <= rp;
            res.volume <= rvol;
            res.last   <= (j + 1'b1 == m);
            j <= j + 1'b1;
            if (j + 1'b1 == m) state <= S_IDLE;
            else begin
              raddr <= sd ? AW'(j + 1'b1) : AW'(n - 2'd2 - j);
              re <= 1'b1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

### design/price_level_order_book.sv
// Top level of the price level order book.
// Command channel: drive kind, side, price, volume and count with start high;
// the transaction is taken at an edge where start is high and busy is low.
// busy drops with the edge that registers the last result, so a new
// transaction can be taken at the end of that result's cycle.
// Results: strobe marks one cycle of status, rank, level_price, level_volume
// and last; the receiver cannot stall, each result shows exactly once.
// Levels live in one memory per side (LEVELS entries of price and volume) with
// registered read data; every access is a read or a write of one entry.
// A volume query or an overwrite scans up to the level's position p; an insert
// or remove then also shifts every level above it; a best levels query reads
// one entry for each of its m results.
// The sequencer takes one transaction at a time and is busy until it is done.
// Reset clears both level counts; memory contents need no clearing since entries
// at or above the count are never used. Unused kind 3 gives no result.
`default_nettype none
module price_level_order_book (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  kind,
  input  wire logic        side,
  input  wire logic [31:0] price,
  input  wire logic [47:0] volume,
  input  wire logic [4:0]  count,
  output logic             strobe,
  output logic [1:0]       status,
  output logic [3:0]       rank,
  output logic [31:0]      level_price,
  output logic [47:0]      level_volume,
  output logic             last
);
  import plob_pkg::*;

  logic          we, wside, rside;
  logic [AW-1:0] waddr, raddr;
  logic [EW-1:0] wdata, rdata, bid_rd, ask_rd;
  res_t          res;

  plob_ram #(.WIDTH(EW), .DEPTH(LEVELS)) u_bid (
    .clk, .we(we && !wside), .waddr, .wdata, .raddr, .rdata(bid_rd)
  );
  plob_ram #(.WIDTH(EW), .DEPTH(LEVELS)) u_ask (
    .clk, .we(we && wside), .waddr, .wdata, .raddr, .rdata(ask_rd)
  );
  assign rdata = rside ? ask_rd : bid_rd;

  plob_seq u_seq (
    .clk, .rst, .start, .kind, .side, .price, .volume, .count, .busy,
    .we, .wside, .waddr, .wdata, .raddr, .rdata, .rside, .res
  );

  assign strobe       = res.valid;
  assign status       = res.status;
  assign rank         = res.rank;
  assign level_price  = res.price;
  assign level_volume = res.volume;
  assign last         = res.last;

`ifndef SYNTHESIS
  a_no_res_idle: assert property (@(posedge clk) disable iff (rst)
    strobe && last |=> !strobe) else $error("result after last");
  a_busy_ok: assert property (@(posedge clk) disable iff (rst)
    strobe && !last |-> busy) else $error("idle mid list");
  a_rank0: assert property (@(posedge clk) disable iff (rst)
    strobe && status != ST_OK |-> rank == 4'd0 && last) else $error("bad status result");
`endif
endmodule
`default_nettype wire

### tb/sv/plob_checker.sv
// Checker for the price level order book: book predictor and result comparison.
`default_nettype none
module plob_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic        busy,
  input  wire logic [1:0]  kind,
  input  wire logic        side,
  input  wire logic [31:0] price,
  input  wire logic [47:0] volume,
  input  wire logic [4:0]  count,
  input  wire logic        strobe,
  input  wire logic [1:0]  status,
  input  wire logic [3:0]  rank,
  input  wire logic [31:0] level_price,
  input  wire logic [47:0] level_volume,
  input  wire logic        last,
  output int               fail_count,
  output int               pending,
  output int               results_seen
);
  import plob_pkg::*;

  typedef struct packed {
    status_t       st;
    logic [3:0]    rk;
    logic [PW-1:0] pr;
    logic [VW-1:0] vo;
    logic          lst;
  } level_res_t;

  // book[0] bids, book[1] asks, ascending price
  logic [PW-1:0] book_px [2][LEVELS];
  logic [VW-1:0] book_vol[2][LEVELS];
  int            book_n  [2];
  level_res_t    expected_q[$];

  function automatic level_res_t mk(status_t s, int r, logic [PW-1:0] p,
                                    logic [VW-1:0] v, logic l);
    level_res_t x;
    x.st = s; x.rk = r[3:0]; x.pr = p; x.vo = v; x.lst = l;
    return x;
  endfunction

  task automatic apply_order(input kind_t k, input logic sd, input logic [PW-1:0] p,
                             input logic [VW-1:0] v, input logic [4:0] c);
    int s, n, pos, m, idx;
    bit hit;
    s = sd;
    n = book_n[s];
    pos = 0;
    while (pos < n && book_px[s][pos] < p) pos++;
    hit = (pos < n) && (book_px[s][pos] == p);
    case (k)
      KIND_DELTA: begin
        if (v == '0) begin
          if (!hit) expected_q.push_back(mk(ST_NOTF, 0, p, '0, 1'b1));
          else begin
            for (int i = pos; i + 1 < n; i++) begin
              book_px[s][i] = book_px[s][i+1];
              book_vol[s][i] = book_vol[s][i+1];
            end
            book_n[s] = n - 1;
            expected_q.push_back(mk(ST_OK, 0, p, '0, 1'b1));
          end
        end else if (hit) begin
          book_vol[s][pos] = v;
          expected_q.push_back(mk(ST_OK, 0, p, v, 1'b1));
        end else if (n >= LEVELS) begin
          expected_q.push_back(mk(ST_FULL, 0, p, '0, 1'b1));
        end else begin
          for (int i = n; i > pos; i--) begin
            book_px[s][i] = book_px[s][i-1];
            book_vol[s][i] = book_vol[s][i-1];
          end
          book_px[s][pos] = p;
          book_vol[s][pos] = v;
          book_n[s] = n + 1;
          expected_q.push_back(mk(ST_OK, 0, p, v, 1'b1));
        end
      end
      KIND_BEST: begin
        m = c;
        if (m > MAX_QUERY) m = MAX_QUERY;
        if (m > n) m = n;
        if (m == 0) expected_q.push_back(mk(ST_EMPTY, 0, '0, '0, 1'b1));
        for (int i = 0; i < m; i++) begin
          idx = sd ? i : n - 1 - i;
          expected_q.push_back(mk(ST_OK, i, book_px[s][idx], book_vol[s][idx],
                                  i + 1 == m));
        end
      end
      KIND_VOL: begin
        if (n == 0) expected_q.push_back(mk(ST_EMPTY, 0, p, '0, 1'b1));
        else if (!hit) expected_q.push_back(mk(ST_NOTF, 0, p, '0, 1'b1));
        else expected_q.push_back(mk(ST_OK, 0, p, book_vol[s][pos], 1'b1));
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    level_res_t want;
    if (rst) begin
      book_n[0] = 0;
      book_n[1] = 0;
      expected_q.delete();
      fail_count <= 0;
      results_seen <= 0;
    end else begin
      // results of an earlier transaction are checked before a new one is queued
      if (strobe) begin
        results_seen <= results_seen + 1;
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result st=%0d rank=%0d px=%0d vol=%0d last=%0d",
                   $time, status, rank, level_price, level_volume, last);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_q.pop_front();
          if (want != {status, rank, level_price, level_volume, last}) begin
            $display("%0t: expected st=%0d rank=%0d px=%0d vol=%0d last=%0d", $time,
                     want.st, want.rk, want.pr, want.vo, want.lst);
            $display("%0t:   actual st=%0d rank=%0d px=%0d vol=%0d last=%0d", $time,
                     status, rank, level_price, level_volume, last);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (start && !busy) apply_order(kind_t'(kind), side, price, volume, count);
    end
    pending <= expected_q.size();
  end
endmodule
`default_nettype wire

### tb/sv/tb_top.sv
// Testbench top: stimulus for the price level order book and final verdict.
`default_nettype none
module tb_top;
  import plob_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  kind = KIND_NONE;
  logic        side = 1'b0;
  logic [31:0] price = '0;
  logic [47:0] volume = '0;
  logic [4:0]  count = '0;
  logic        strobe;
  logic [1:0]  status;
  logic [3:0]  rank;
  logic [31:0] level_price;
  logic [47:0] level_volume;
  logic        last;
  int          fail_count, pending, results_seen;
  int          accepted = 0;
  int          idle_cycles = 0;
  logic [31:0] px_pool[8];

  localparam int WATCHDOG = 5000;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  price_level_order_book i_dut (.*);

  plob_checker i_chk (.*);

  // cycles with no transaction on either side
  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG) begin
      $display("watchdog expired after %0d quiet cycles", WATCHDOG);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic send_order(input kind_t k, input logic sd, input logic [31:0] p,
                            input logic [47:0] v, input logic [4:0] c);
    kind <= k; side <= sd; price <= p; volume <= v; count <= c;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    accepted++;
    @(negedge clk);
  endtask

  task automatic pause_sender();
    start <= 1'b0;
    repeat ($urandom_range(1, 12)) @(negedge clk);
  endtask

  function automatic logic [47:0] rand_vol();
    case ($urandom_range(0, 3))
      0: return 48'({$urandom, $urandom});
      1: return 48'hFFFF_FFFF_FFFF;
      default: return 48'($urandom_range(1, 1000));
    endcase
  endfunction

  initial begin
    int burst, sel;
    kind_t k;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: empty sides, extremes, removal, overwrite, every kind
    send_order(KIND_BEST, 1'b0, 32'd0, 48'd0, 5'd16);
    send_order(KIND_VOL, 1'b1, 32'd7, 48'd0, 5'd0);
    send_order(KIND_DELTA, 1'b0, 32'd5, 48'd0, 5'd0);
    send_order(KIND_DELTA, 1'b0, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 5'd0);
    send_order(KIND_DELTA, 1'b0, 32'd0, 48'd1, 5'd0);
    send_order(KIND_DELTA, 1'b0, 32'd100, 48'd50, 5'd0);
    send_order(KIND_DELTA, 1'b0, 32'd100, 48'd77, 5'd0);
    send_order(KIND_DELTA, 1'b1, 32'd0, 48'hFFFF_FFFF_FFFF, 5'd0);
    send_order(KIND_DELTA, 1'b1, 32'hFFFF_FFFF, 48'd3, 5'd0);
    send_order(KIND_VOL, 1'b0, 32'd100, 48'd0, 5'd0);
    send_order(KIND_VOL, 1'b0, 32'd101, 48'd0, 5'd0);
    send_order(KIND_BEST, 1'b0, 32'd0, 48'd0, 5'd0);
    send_order(KIND_BEST, 1'b0, 32'd0, 48'd0, 5'd31);
    send_order(KIND_BEST, 1'b1, 32'd0, 48'd0, 5'd1);
    send_order(KIND_NONE, 1'b1, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 5'd31);
    send_order(KIND_DELTA, 1'b0, 32'd100, 48'd0, 5'd0);
    send_order(KIND_DELTA, 1'b0, 32'd100, 48'd0, 5'd0);
    // fill the bid side past capacity
    for (int i = 0; i < LEVELS + 2; i++) send_order(KIND_DELTA, 1'b0,
                                                  32'(1000 + i * 3), 48'd9, 5'd0);
    send_order(KIND_BEST, 1'b0, 32'd0, 48'd0, 5'd20);
    for (int i = 0; i < LEVELS; i += 2) send_order(KIND_DELTA, 1'b0, 32'(1000 + i * 3),
                                                   48'd0, 5'd0);

    for (int i = 0; i < 8; i++) px_pool[i] = $urandom;
    // random part: mostly prices near a small ladder so hits are common
    while (accepted < 460) begin
      burst = $urandom_range(1, 20);
      for (int b = 0; b < burst; b++) begin
        sel = $urandom_range(0, 99);
        k = sel < 55 ? KIND_DELTA : sel < 75 ? KIND_BEST : sel < 95 ? KIND_VOL
                                                          : KIND_NONE;
        send_order(k, 1'($urandom_range(0, 1)),
                   $urandom_range(0, 3) == 0 ? $urandom
                     : px_pool[$urandom_range(0, 7)] + $urandom_range(0, 40),
                   $urandom_range(0, 3) == 0 ? 48'd0 : rand_vol(),
                   5'($urandom_range(0, 31)));
      end
      if ($urandom_range(0, 2) != 0) pause_sender();
    end
    start <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    $display("%0d commands accepted, %0d results checked across both sides",
             accepted, results_seen);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d failures", fail_count);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
`default_nettype wire
